[rtl/core/wspf_pkg.sv]
// shared types and constants of the wheel speed pid feedforward block
package wspf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_BASE  = 3'd0,
        REG_KP_VERT  = 3'd1,
        REG_KD_VERT  = 3'd2,
        REG_KI_VERT  = 3'd3,
        REG_LIM_VERT = 3'd4,
        REG_KP_HORIZ = 3'd5,
        REG_KD_HORIZ = 3'd6,
        REG_KI_HORIZ = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  ff_base;
        logic [7:0]  kp_vert;
        logic [7:0]  kd_vert;
        logic [7:0]  ki_vert;
        logic [14:0] lim_vert;
        logic [7:0]  kp_horiz;
        logic [7:0]  kd_horiz;
        logic [7:0]  ki_horiz;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic              wheel;
        logic signed [11:0] target;
        logic signed [11:0] speed;
        logic [8:0]        angle;
    } t_in_item;

    typedef struct packed {
        logic               zero;
        logic               kind;
        logic               wheel;
        logic signed [11:0] target;
        logic signed [12:0] err;
        logic signed [13:0] diff;
        logic signed [15:0] acc;
        logic signed [10:0] kff;
        logic [7:0]         kp;
        logic [7:0]         kd;
        logic [7:0]         ki;
    } t_err_stage;

    typedef struct packed {
        logic               zero;
        logic               kind;
        logic               wheel;
        logic               neg;
        logic signed [22:0] p_ff;
        logic signed [21:0] p_p;
        logic signed [22:0] p_d;
        logic signed [24:0] p_i;
    } t_prod_stage;

endpackage

[rtl/core/wheel_speed_pid_feedforward.sv]
// top level of the two-wheel pid speed controller with feedforward
//
// usage:
//  - slave stream carries one wheel update per transaction; tuser is the
//    mode (0 horizontal, 1 vertical with angle feedforward)
//  - master stream returns one drive value per accepted transaction, in order
//  - config port writes one register per cycle with i_cfg_we; write only
//    while the block is empty
//  - pipeline: input register, error stage, multiplier stage, output
//    register; each transaction passes through them in this order
//  - throughput one transaction per cycle while the receiver takes results;
//    the per-wheel error state is updated as an item loads into the error
//    stage, so back-to-back updates of the same wheel need no forwarding
//  - when the receiver stalls, the stages fill one by one and the input
//    keeps taking transactions until no bubble is left, then tready drops
//  - reset clears the valid bits, both wheels' error history and loads the
//    register defaults; no clearing pass
module wheel_speed_pid_feedforward #(
    parameter int CTRL_LIMIT        = 24000,
    parameter int MOTOR_FULL_RANGE  = 2048,
    parameter int HORIZ_INTEG_LIMIT = 3200
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata from lsb: wheel[0], target_pwm[12:1], measured_speed[24:13],
    // tilt_angle[33:25], zero fill[39:34]
    input  logic [39:0]                     i_s_tdata,
    // tuser: kind[0]
    input  logic                            i_s_tuser,
    // master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata from lsb: drive_pwm[11:0], wheel_out[12], zero fill[15:13]
    output logic [15:0]                     o_m_tdata,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [wspf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wspf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wspf_pkg::*;

    t_cfg        cfg;
    t_in_item    r_item;
    t_err_stage  err_stage;
    t_prod_stage prod_stage;
    logic [11:0] drive;
    logic        wheel_out;

    // stage valid bits: input, error, product, output
    logic r_v1, r_v2, r_v3, r_v4;
    logic ld1, ld2, ld3, ld4;

    // each stage loads when its successor is empty or moving
    assign ld4 = r_v3 & (~r_v4 | i_m_tready);
    assign ld3 = r_v2 & (~r_v3 | ld4);
    assign ld2 = r_v1 & (~r_v2 | ld3);
    assign o_s_tready = ~r_v1 | ld2;
    assign ld1 = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= ld1 | (r_v1 & ~ld2);
            r_v2 <= ld2 | (r_v2 & ~ld3);
            r_v3 <= ld3 | (r_v3 & ~ld4);
            r_v4 <= ld4 | (r_v4 & ~i_m_tready);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_item.kind   <= i_s_tuser;
            r_item.wheel  <= i_s_tdata[0];
            r_item.target <= $signed(i_s_tdata[12:1]);
            r_item.speed  <= $signed(i_s_tdata[24:13]);
            r_item.angle  <= i_s_tdata[33:25];
        end
    end

    wspf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    wspf_error #(
        .HORIZ_INTEG_LIMIT (HORIZ_INTEG_LIMIT)
    ) u_error (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld2),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_stage (err_stage)
    );

    wspf_mult u_mult (
        .i_clk   (i_clk),
        .i_load  (ld3),
        .i_stage (err_stage),
        .o_prod  (prod_stage)
    );

    wspf_post #(
        .CTRL_LIMIT       (CTRL_LIMIT),
        .MOTOR_FULL_RANGE (MOTOR_FULL_RANGE)
    ) u_post (
        .i_clk   (i_clk),
        .i_load  (ld4),
        .i_prod  (prod_stage),
        .o_drive (drive),
        .o_wheel (wheel_out)
    );

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {3'b000, wheel_out, drive};

endmodule

[rtl/core/wspf_cfg.sv]
// configuration register file with reset defaults
module wspf_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wspf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wspf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output wspf_pkg::t_cfg                  o_cfg
);
    import wspf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_FF_BASE:  n_cfg.ff_base  = i_cfg_data[7:0];
                REG_KP_VERT:  n_cfg.kp_vert  = i_cfg_data[7:0];
                REG_KD_VERT:  n_cfg.kd_vert  = i_cfg_data[7:0];
                REG_KI_VERT:  n_cfg.ki_vert  = i_cfg_data[7:0];
                REG_LIM_VERT: n_cfg.lim_vert = i_cfg_data[14:0];
                REG_KP_HORIZ: n_cfg.kp_horiz = i_cfg_data[7:0];
                REG_KD_HORIZ: n_cfg.kd_horiz = i_cfg_data[7:0];
                REG_KI_HORIZ: n_cfg.ki_horiz = i_cfg_data[7:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ff_base  <= 8'd20;
            r_cfg.kp_vert  <= 8'd40;
            r_cfg.kd_vert  <= 8'd5;
            r_cfg.ki_vert  <= 8'd10;
            r_cfg.lim_vert <= 15'd3200;
            r_cfg.kp_horiz <= 8'd40;
            r_cfg.kd_horiz <= 8'd5;
            r_cfg.ki_horiz <= 8'd10;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/wspf_error.sv]
// per-wheel error state, clamped error sum and feedforward gain stage
module wspf_error #(
    parameter int HORIZ_INTEG_LIMIT = 3200
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  wspf_pkg::t_in_item   i_item,
    input  wspf_pkg::t_cfg       i_cfg,
    output wspf_pkg::t_err_stage o_stage
);
    import wspf_pkg::*;

    localparam logic signed [16:0] HorizLim = 17'(HORIZ_INTEG_LIMIT);

    logic signed [12:0] r_now [2];
    logic signed [15:0] r_sum [2];
    t_err_stage         r_stage;
    t_err_stage         n_stage;

    logic signed [12:0] tgt13;
    logic signed [12:0] spd13;
    logic signed [16:0] acc17;
    logic signed [16:0] lim17;
    logic signed [10:0] ang11;
    logic signed [10:0] tmp11;
    logic signed [10:0] corr;

    always_comb begin
        tgt13 = 13'(i_item.target);
        spd13 = 13'(i_item.speed);

        n_stage.zero   = (i_item.target == 12'sd0);
        n_stage.kind   = i_item.kind;
        n_stage.wheel  = i_item.wheel;
        n_stage.target = i_item.target;
        // error sign follows the target direction
        n_stage.err    = i_item.target[11] ? (tgt13 + spd13) : (tgt13 - spd13);
        n_stage.diff   = 14'(n_stage.err) - 14'(r_now[i_item.wheel]);

        acc17 = 17'(r_sum[i_item.wheel]) + 17'(n_stage.err);
        lim17 = i_item.kind ? $signed({2'b00, i_cfg.lim_vert}) : HorizLim;
        if (acc17 > lim17) begin
            acc17 = lim17;
        end else if (acc17 < -lim17) begin
            acc17 = -lim17;
        end
        n_stage.acc = 16'(acc17);

        // angle quadrant correction, floor shifts
        ang11 = $signed({2'b00, i_item.angle});
        if (i_item.angle >= 9'd270) begin
            tmp11 = 11'sd360 - ang11;
            corr  = -(tmp11 >>> 2);
        end else if (i_item.angle >= 9'd90) begin
            tmp11 = 11'sd180 - ang11;
            corr  = tmp11 >>> 2;
        end else begin
            tmp11 = ang11;
            corr  = tmp11 >>> 2;
        end

        if (i_item.kind) begin
            n_stage.kff = $signed({3'b000, i_cfg.ff_base})
                        + (i_item.target[11] ? -corr : corr);
            n_stage.kp  = i_cfg.kp_vert;
            n_stage.kd  = i_cfg.kd_vert;
            n_stage.ki  = i_cfg.ki_vert;
        end else begin
            n_stage.kff = 11'sd8;
            n_stage.kp  = i_cfg.kp_horiz;
            n_stage.kd  = i_cfg.kd_horiz;
            n_stage.ki  = i_cfg.ki_horiz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now[0] <= '0;
            r_now[1] <= '0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
        end else if (i_load) begin
            if (n_stage.zero) begin
                r_now[i_item.wheel] <= '0;
                r_sum[i_item.wheel] <= '0;
            end else begin
                r_now[i_item.wheel] <= n_stage.err;
                r_sum[i_item.wheel] <= n_stage.acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[rtl/core/wspf_mult.sv]
// four parallel gain multipliers with registered products
module wspf_mult (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  wspf_pkg::t_err_stage  i_stage,
    output wspf_pkg::t_prod_stage o_prod
);
    import wspf_pkg::*;

    t_prod_stage r_prod;
    t_prod_stage n_prod;

    always_comb begin
        n_prod.zero = i_stage.zero;
        n_prod.kind = i_stage.kind;
        n_prod.wheel = i_stage.wheel;
        n_prod.neg  = i_stage.target[11];
        n_prod.p_ff = 23'(i_stage.kff) * 23'(i_stage.target);
        n_prod.p_p  = 22'($signed({1'b0, i_stage.kp})) * 22'(i_stage.err);
        n_prod.p_d  = 23'(i_stage.diff) * 23'($signed({1'b0, i_stage.kd}));
        n_prod.p_i  = 25'(i_stage.acc) * 25'($signed({1'b0, i_stage.ki}));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/wspf_post.sv]
// term sum, direction block, clamps, scaling, horizontal offset and output register
module wspf_post #(
    parameter int CTRL_LIMIT       = 24000,
    parameter int MOTOR_FULL_RANGE = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  wspf_pkg::t_prod_stage i_prod,
    output logic [11:0]           o_drive,
    output logic                  o_wheel
);
    import wspf_pkg::*;

    localparam logic signed [26:0] CtrlLim = 27'(CTRL_LIMIT);
    localparam logic signed [15:0] HalfLim = 16'(MOTOR_FULL_RANGE / 2);

    logic signed [26:0] sum;
    logic signed [26:0] shifted;
    logic signed [15:0] res;
    logic [11:0]        r_drive;
    logic [11:0]        n_drive;
    logic               r_wheel;

    always_comb begin
        sum = 27'(i_prod.p_ff) + 27'(i_prod.p_p) - 27'(i_prod.p_d) + 27'(i_prod.p_i);
        // no reversal of direction
        if (sum < 27'sd0 && !i_prod.neg) begin
            sum = '0;
        end
        if (sum > 27'sd0 && i_prod.neg) begin
            sum = '0;
        end
        if (sum > CtrlLim) begin
            sum = CtrlLim;
        end
        if (sum < -CtrlLim) begin
            sum = -CtrlLim;
        end
        shifted = sum >>> 4;
        res     = 16'(shifted);
        if (!i_prod.kind) begin
            if (res > 16'sd0) begin
                res = res + 16'sd30;
            end else if (res < 16'sd0) begin
                res = res - 16'sd30;
            end
        end
        if (res > HalfLim) begin
            res = HalfLim;
        end
        if (res < -HalfLim) begin
            res = -HalfLim;
        end
        n_drive = i_prod.zero ? 12'd0 : res[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= n_drive;
            r_wheel <= i_prod.wheel;
        end
    end

    assign o_drive = r_drive;
    assign o_wheel = r_wheel;

endmodule

[verif/wheel_speed_pid_feedforward_test.sv]
// self-checking stream testbench for the two-wheel pid speed controller with feedforward
module wheel_speed_pid_feedforward_test;
    import wspf_pkg::*;

    localparam int CTRL_LIMIT        = 24000;
    localparam int MOTOR_FULL_RANGE  = 2048;
    localparam int HORIZ_INTEG_LIMIT = 3200;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int HOLD_CYCLES       = 300;
    localparam int END_PAD_CYCLES    = 10;

    // operating mode travels on tuser
    localparam logic MODE_HORIZ = 1'b0;
    localparam logic MODE_VERT  = 1'b1;

    typedef struct packed {
        logic        wheel;
        logic [11:0] drive;
    } t_drive_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [39:0]           i_s_tdata  = '0;
    logic                  i_s_tuser  = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [15:0]           o_m_tdata;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // register mirror, starts at the reset defaults
    t_cfg gain_cfg = '{8'd20, 8'd40, 8'd5, 8'd10, 15'd3200, 8'd40, 8'd5, 8'd10};

    // per-wheel controller history as the block should hold it
    logic signed [12:0] wheel_err[2]      = '{13'sd0, 13'sd0};
    logic signed [12:0] wheel_err_prev[2] = '{13'sd0, 13'sd0};
    logic signed [15:0] wheel_err_sum[2]  = '{16'sd0, 16'sd0};

    t_in_item      wheel_jobs[$];    // updates waiting to be offered
    t_drive_result drive_expect[$];  // drive values owed by the block, oldest first
    t_drive_result drive_seen;

    int  fail_count   = 0;
    int  cycle_count  = 0;
    int  hold_asks    = 0;
    int  holds_served = 0;
    int  hold_left    = 0;
    bit  steady       = 1'b0;

    wheel_speed_pid_feedforward #(
        .CTRL_LIMIT        (CTRL_LIMIT),
        .MOTOR_FULL_RANGE  (MOTOR_FULL_RANGE),
        .HORIZ_INTEG_LIMIT (HORIZ_INTEG_LIMIT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // drive value for one update; advances the wheel history like the block does
    function automatic t_drive_result predict_drive(input t_in_item it);
        t_drive_result r;
        int tgt, spd, ang, corr, kff, kp, kd, ki, lim, err, prev, acc, res;
        int half;
        half = MOTOR_FULL_RANGE / 2;
        tgt = int'(it.target);
        spd = int'(it.speed);
        ang = int'(it.angle);
        r.wheel = it.wheel;
        if (tgt == 0) begin
            // zero target wipes the wheel's history
            wheel_err[it.wheel]      = '0;
            wheel_err_prev[it.wheel] = '0;
            wheel_err_sum[it.wheel]  = '0;
            r.drive = '0;
            return r;
        end
        if (it.kind == MODE_VERT) begin
            // angle quadrant correction, out-of-range angles taken literally
            if (ang >= 270) begin
                corr = -((360 - ang) >>> 2);
            end else if (ang >= 90) begin
                corr = (180 - ang) >>> 2;
            end else begin
                corr = ang >>> 2;
            end
            kff = int'(gain_cfg.ff_base) + ((tgt > 0) ? corr : -corr);
            kp  = int'(gain_cfg.kp_vert);
            kd  = int'(gain_cfg.kd_vert);
            ki  = int'(gain_cfg.ki_vert);
            lim = int'(gain_cfg.lim_vert);
        end else begin
            kff = 8;
            kp  = int'(gain_cfg.kp_horiz);
            kd  = int'(gain_cfg.kd_horiz);
            ki  = int'(gain_cfg.ki_horiz);
            lim = HORIZ_INTEG_LIMIT;
        end
        prev = int'(wheel_err[it.wheel]);
        wheel_err_prev[it.wheel] = wheel_err[it.wheel];
        err = (tgt >= 0) ? tgt - spd : tgt + spd;
        wheel_err[it.wheel] = err[12:0];
        // sum clamped with the current mode's limit only
        acc = int'(wheel_err_sum[it.wheel]) + err;
        if (acc > lim) begin
            acc = lim;
        end else if (acc < -lim) begin
            acc = -lim;
        end
        wheel_err_sum[it.wheel] = acc[15:0];
        res = kff * tgt + kp * err - (err - prev) * kd + ki * acc;
        // no drive against the commanded direction
        if (res < 0 && tgt >= 0) res = 0;
        if (res > 0 && tgt < 0) res = 0;
        if (res > CTRL_LIMIT) res = CTRL_LIMIT;
        if (res < -CTRL_LIMIT) res = -CTRL_LIMIT;
        res = res >>> 4;
        if (it.kind == MODE_HORIZ) begin
            if (res > 0) begin
                res = res + 30;
            end else if (res < 0) begin
                res = res - 30;
            end
        end
        if (res > half) res = half;
        if (res < -half) res = -half;
        r.drive = res[11:0];
        return r;
    endfunction

    // sender: keeps an offered transaction stable until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!(i_s_tvalid && !o_s_tready)) begin
            if (i_s_tvalid) begin
                drive_expect.push_back(predict_drive(wheel_jobs[0]));
                void'(wheel_jobs.pop_front());
            end
            if (wheel_jobs.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {6'b0, wheel_jobs[0].angle, wheel_jobs[0].speed,
                               wheel_jobs[0].target, wheel_jobs[0].wheel};
                i_s_tuser  <= wheel_jobs[0].kind;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus long holds on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (hold_asks != holds_served) begin
                holds_served = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= steady || ($urandom_range(99) >= 20);
            end
        end
    end

    // result checker, in order against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (drive_expect.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result transaction: wheel %0d drive %0d",
                             o_m_tdata[12], $signed(o_m_tdata[11:0]));
                end
                fail_count++;
            end else begin
                drive_seen = drive_expect.pop_front();
                if (o_m_tdata[11:0] !== drive_seen.drive || o_m_tdata[12] !== drive_seen.wheel)
                begin
                    if (fail_count < 10) begin
                        $display("drive mismatch: expected wheel %0d drive %0d, got wheel %0d drive %0d",
                                 drive_seen.wheel, $signed(drive_seen.drive),
                                 o_m_tdata[12], $signed(o_m_tdata[11:0]));
                    end
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_item(input logic kind, input logic wheel, input int target,
                             input int speed, input int angle);
        t_in_item it;
        it.kind   = kind;
        it.wheel  = wheel;
        it.target = target[11:0];
        it.speed  = speed[11:0];
        it.angle  = angle[8:0];
        wheel_jobs.push_back(it);
    endtask

    // one register write, mirror updated with the block's masking
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_FF_BASE:  gain_cfg.ff_base  = val[7:0];
            REG_KP_VERT:  gain_cfg.kp_vert  = val[7:0];
            REG_KD_VERT:  gain_cfg.kd_vert  = val[7:0];
            REG_KI_VERT:  gain_cfg.ki_vert  = val[7:0];
            REG_LIM_VERT: gain_cfg.lim_vert = val[14:0];
            REG_KP_HORIZ: gain_cfg.kp_horiz = val[7:0];
            REG_KD_HORIZ: gain_cfg.kd_horiz = val[7:0];
            REG_KI_HORIZ: gain_cfg.ki_horiz = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // the 8-bit registers get junk in the unused upper data bits
    task automatic load_setting(input t_cfg s);
        write_reg(REG_FF_BASE,  {7'($urandom), s.ff_base});
        write_reg(REG_KP_VERT,  {7'($urandom), s.kp_vert});
        write_reg(REG_KD_VERT,  {7'($urandom), s.kd_vert});
        write_reg(REG_KI_VERT,  {7'($urandom), s.ki_vert});
        write_reg(REG_LIM_VERT, s.lim_vert);
        write_reg(REG_KP_HORIZ, {7'($urandom), s.kp_horiz});
        write_reg(REG_KD_HORIZ, {7'($urandom), s.kd_horiz});
        write_reg(REG_KI_HORIZ, {7'($urandom), s.ki_horiz});
    endtask

    function automatic t_cfg random_setting(input int lim_max);
        t_cfg s;
        s.ff_base  = 8'($urandom);
        s.kp_vert  = 8'($urandom);
        s.kd_vert  = 8'($urandom);
        s.ki_vert  = 8'($urandom);
        s.lim_vert = 15'($urandom_range(lim_max));
        s.kp_horiz = 8'($urandom);
        s.kd_horiz = 8'($urandom);
        s.ki_horiz = 8'($urandom);
        return s;
    endfunction

    // runs of steady control on a held target and mode, with some noise mixed in
    task automatic queue_wheel_runs(input int count);
        int  n, r, run_left, run_target, tgt, spd, ang;
        logic run_kind, kind;
        run_left   = 0;
        run_target = 1;
        run_kind   = MODE_HORIZ;
        for (n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left   = $urandom_range(4, 40);
                run_kind   = 1'($urandom_range(1));
                run_target = $urandom_range(2048) - 1024;
                if (run_target == 0) run_target = 512;
            end
            run_left--;
            kind = ($urandom_range(99) < 90) ? run_kind : ~run_kind;
            r = $urandom_range(99);
            if (r < 5) begin
                tgt = 0;
            end else if (r < 8) begin
                tgt = $signed(12'($urandom));
            end else if (r < 16) begin
                case ($urandom_range(3))
                    0: tgt = -1024;
                    1: tgt = 1024;
                    2: tgt = 1;
                    default: tgt = -1;
                endcase
            end else if (r < 60) begin
                tgt = run_target;
            end else begin
                tgt = $urandom_range(2048) - 1024;
            end
            // about half the time the wheel tracks its target closely
            if ($urandom_range(1) == 0) begin
                spd = ((tgt >= 0) ? tgt : -tgt) + $urandom_range(128) - 64;
            end else begin
                spd = $urandom;
            end
            ang = ($urandom_range(99) < 90) ? $urandom_range(359) : $urandom_range(511);
            push_item(kind, 1'($urandom_range(1)), tgt, spd, ang);
        end
    endtask

    task automatic wait_drained();
        while (wheel_jobs.size() != 0 || drive_expect.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_cfg s, input int count, input bit no_gaps,
                             input bit long_hold);
        load_setting(s);
        steady = no_gaps;
        queue_wheel_runs(count);
        if (long_hold) hold_asks++;
        wait_drained();
        steady = 1'b0;
    endtask

    initial begin
        t_cfg s;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with the reset gains
        push_item(MODE_HORIZ, 1'b0, 0, 100, 0);         // zero target clears
        push_item(MODE_HORIZ, 1'b0, 1024, 0, 0);
        push_item(MODE_HORIZ, 1'b0, 1024, 2047, 0);     // reversal blocked
        push_item(MODE_HORIZ, 1'b1, -1024, 0, 0);
        push_item(MODE_HORIZ, 1'b1, -1024, -2048, 0);   // negative target error sign
        push_item(MODE_HORIZ, 1'b1, -1, 0, 0);
        push_item(MODE_HORIZ, 1'b0, 1, 1, 0);           // tiny drive plus offset
        push_item(MODE_HORIZ, 1'b0, 1, 0, 0);
        // every quadrant edge and angles past a full turn
        push_item(MODE_VERT, 1'b0, 500, 400, 0);
        push_item(MODE_VERT, 1'b0, 500, 400, 89);
        push_item(MODE_VERT, 1'b0, 500, 400, 90);
        push_item(MODE_VERT, 1'b0, 500, 400, 180);
        push_item(MODE_VERT, 1'b0, 500, 400, 269);
        push_item(MODE_VERT, 1'b0, 500, 400, 270);
        push_item(MODE_VERT, 1'b0, 500, 400, 359);
        push_item(MODE_VERT, 1'b0, 500, 400, 360);
        push_item(MODE_VERT, 1'b0, 500, 400, 511);
        push_item(MODE_VERT, 1'b1, -700, -650, 45);
        push_item(MODE_VERT, 1'b1, -700, -650, 300);
        push_item(MODE_VERT, 1'b1, -700, -650, 450);
        // error sum runs into its clamp, then output saturates
        push_item(MODE_VERT, 1'b1, 1024, -2048, 10);
        push_item(MODE_VERT, 1'b1, 1024, -2048, 10);
        push_item(MODE_VERT, 1'b1, 1024, -2048, 10);
        push_item(MODE_HORIZ, 1'b1, 0, -2048, 10);
        push_item(MODE_VERT, 1'b0, 0, 2047, 359);
        wait_drained();

        // random part across several gain settings, extremes included
        run_phase('1, 270, 1'b1, 1'b0);                 // all gains at maximum, no gaps
        run_phase('0, 200, 1'b0, 1'b0);                 // all gains and limit zero
        run_phase(random_setting(32767), 300, 1'b0, 1'b1);
        run_phase(random_setting(60), 270, 1'b0, 1'b0);  // tight vertical sum limit
        run_phase(random_setting(32767), 300, 1'b0, 1'b0);
        s = '{8'd20, 8'd40, 8'd5, 8'd10, 15'd3200, 8'd40, 8'd5, 8'd10};
        run_phase(s, 270, 1'b0, 1'b0);
        run_phase(random_setting(8000), 270, 1'b0, 1'b0);

        repeat (END_PAD_CYCLES) @(posedge i_clk);
        if (drive_expect.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/wspf_pkg.sv
rtl/core/wspf_cfg.sv
rtl/core/wspf_error.sv
rtl/core/wspf_mult.sv
rtl/core/wspf_post.sv
rtl/core/wheel_speed_pid_feedforward.sv
verif/wheel_speed_pid_feedforward_test.sv
